@@ hw/rtl/sfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants of the settings frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned POS_W    = 3;
   localparam int unsigned SHIFT_W  = 40;
   localparam int unsigned IDENT_W  = 16;
   localparam int unsigned VALUE_W  = 32;

   localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_END     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LENGTH = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PUSH   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_WINDOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FRAME  = 3'd4;

   localparam logic [IDENT_W-1:0] ID_TABLE_SIZE  = 16'd1;
   localparam logic [IDENT_W-1:0] ID_PUSH        = 16'd2;
   localparam logic [IDENT_W-1:0] ID_STREAMS     = 16'd3;
   localparam logic [IDENT_W-1:0] ID_WINDOW      = 16'd4;
   localparam logic [IDENT_W-1:0] ID_FRAME_SIZE  = 16'd5;
   localparam logic [IDENT_W-1:0] ID_LIST_SIZE   = 16'd6;

   localparam logic [POS_W-1:0] LAST_POS = 3'd5;

   localparam logic [23:0] MIN_FRAME_SIZE = 24'd16384;

   typedef struct packed {
      logic [31:0] table_size;
      logic        push;
      logic [31:0] streams;
      logic [30:0] window;
      logic [23:0] frame_size;
      logic [31:0] list_size;
   } settings_type;

   localparam settings_type SET_DEFAULT = '{
      table_size: 32'd4096,
      push:       1'b1,
      streams:    32'hFFFF_FFFF,
      window:     31'd65535,
      frame_size: 24'd16384,
      list_size:  32'hFFFF_FFFF
   };

   typedef struct packed {
      logic               done;
      logic               pos_nonzero;
      logic [IDENT_W-1:0] ident;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      settings_type        live;
   } result_type;

endpackage

@@ hw/rtl/sfp_assembler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_assembler
// Collects payload bytes into 6-byte identifier/value entries.
// ----------------------------------------------------------------------------
module sfp_assembler
   import sfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             beat,
   input  logic [CMD_W-1:0] command,
   input  logic [7:0]       payload_byte,
   output entry_type        entry
);

   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic               last;

   assign last = (pos_ff >= LAST_POS);

   always_comb begin
      pos_in   = pos_ff;
      shift_in = shift_ff;
      if (beat) begin
         case (command) inside
            CMD_BYTE: begin
               if (last) begin
                  pos_in   = '0;
                  shift_in = '0;
               end else begin
                  pos_in   = pos_ff + POS_W'(1);
                  shift_in = {shift_ff[SHIFT_W-9:0], payload_byte};
               end
            end
            CMD_END, CMD_RESTORE: begin
               pos_in   = '0;
               shift_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      entry.done        = beat && (command == CMD_BYTE) && last;
      entry.pos_nonzero = (pos_ff != '0);
      entry.ident       = shift_ff[39:24];
      entry.value       = {shift_ff[23:0], payload_byte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         shift_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
      end
   end

endmodule

@@ hw/rtl/sfp_settings.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_settings
// Pending and live settings, entry range checks, commit and restore.
// ----------------------------------------------------------------------------
module sfp_settings
   import sfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             beat,
   input  logic [CMD_W-1:0] command,
   input  entry_type        entry,
   output logic             result_push,
   output result_type       result
);

   settings_type        live_ff,  live_in;
   settings_type        pend_ff,  pend_in;
   logic [STATUS_W-1:0] error_ff, error_in;
   settings_type        pend_upd;
   logic [STATUS_W-1:0] error_upd;
   settings_type        commit;

   // range checks on a finished entry
   always_comb begin
      pend_upd  = pend_ff;
      error_upd = error_ff;
      if (entry.done && (error_ff == ST_OK)) begin
         case (entry.ident)
            ID_TABLE_SIZE: pend_upd.table_size = entry.value;
            ID_PUSH: begin
               if (entry.value[31:1] != '0) begin
                  error_upd = ST_PUSH;
               end else begin
                  pend_upd.push = entry.value[0];
               end
            end
            ID_STREAMS: pend_upd.streams = entry.value;
            ID_WINDOW: begin
               if (entry.value[31]) begin
                  error_upd = ST_WINDOW;
               end else begin
                  pend_upd.window = entry.value[30:0];
               end
            end
            ID_FRAME_SIZE: begin
               if ((entry.value[31:24] != '0) || (entry.value[23:0] < MIN_FRAME_SIZE)) begin
                  error_upd = ST_FRAME;
               end else begin
                  pend_upd.frame_size = entry.value[23:0];
               end
            end
            ID_LIST_SIZE: pend_upd.list_size = entry.value;
            default: begin
            end
         endcase
      end
   end

   assign commit = entry.pos_nonzero ? live_ff : pend_ff;

   always_comb begin
      live_in     = live_ff;
      pend_in     = pend_ff;
      error_in    = error_ff;
      result_push = 1'b0;
      result      = '{status: ST_OK, live: commit};
      if (beat) begin
         case (command)
            CMD_BYTE: begin
               pend_in  = pend_upd;
               error_in = error_upd;
            end
            CMD_END: begin
               live_in       = commit;
               pend_in       = commit;
               error_in      = ST_OK;
               result_push   = 1'b1;
               result.status = entry.pos_nonzero ? ST_LENGTH : error_ff;
            end
            CMD_RESTORE: begin
               live_in  = SET_DEFAULT;
               pend_in  = SET_DEFAULT;
               error_in = ST_OK;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= SET_DEFAULT;
         pend_ff  <= SET_DEFAULT;
         error_ff <= ST_OK;
      end else begin
         live_ff  <= live_in;
         pend_ff  <= pend_in;
         error_ff <= error_in;
      end
   end

endmodule

@@ hw/rtl/sfp_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_out_buf
// Result register with a skid stage so the input side keeps moving.
// ----------------------------------------------------------------------------
module sfp_out_buf
   import sfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   logic       out_valid_ff,  out_valid_in;
   result_type out_data_ff,   out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff,  skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !out_stall) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // skid only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid beat without result beat");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("beat pushed into full skid");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_stall && !skid_valid_ff && !push) |=> !out_valid_ff)
      else $error("result beat repeated");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !out_stall) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid beat lost");

endmodule

@@ hw/rtl/settings_frame_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// settings_frame_parser_top
// HTTP/2 SETTINGS payload parser with pending and live settings.
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat per command; command byte shifts payload_byte into
//   the current 6-byte entry, end closes the frame, restore reloads defaults.
//   each finished entry is range checked and applied to the pending copy;
//   after the first bad entry nothing more is applied in that frame.
//   rsp channel: one beat per end command with status and the live settings,
//   committed only when the payload length is a multiple of six.
// timing
//   one req beat accepted per cycle while req_stall is low; state updates in
//   the cycle of acceptance. the rsp beat for an end beat is registered in the
//   result register, or in the skid entry while rsp is stalled.
// stall
//   a result register plus one skid entry sit on the rsp side; req_stall
//   rises only when both hold a beat, and drops once rsp takes one.
// reset
//   synchronous; live and pending settings take protocol defaults, the entry
//   in progress and the recorded error are cleared, no rsp beat is pending.
// ----------------------------------------------------------------------------
module settings_frame_parser_top
   import sfp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [7:0]          req_payload_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [31:0]         rsp_table_size,
   output logic                rsp_push_allowed,
   output logic [31:0]         rsp_stream_limit,
   output logic [30:0]         rsp_start_window,
   output logic [23:0]         rsp_frame_limit,
   output logic [31:0]         rsp_list_limit
);

   logic       beat;
   logic       full;
   entry_type  entry;
   logic       result_push;
   result_type result;
   result_type rsp_data;

   assign beat      = req_valid && !full;
   assign req_stall = full;

   sfp_assembler u_assembler (
      .clock        (clock),
      .reset        (reset),
      .beat         (beat),
      .command      (req_command),
      .payload_byte (req_payload_byte),
      .entry        (entry)
   );

   sfp_settings u_settings (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .command     (req_command),
      .entry       (entry),
      .result_push (result_push),
      .result      (result)
   );

   sfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_status       = rsp_data.status;
   assign rsp_table_size   = rsp_data.live.table_size;
   assign rsp_push_allowed = rsp_data.live.push;
   assign rsp_stream_limit = rsp_data.live.streams;
   assign rsp_start_window = rsp_data.live.window;
   assign rsp_frame_limit  = rsp_data.live.frame_size;
   assign rsp_list_limit   = rsp_data.live.list_size;

endmodule
